[sv/nta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest track association package
// Shared types, field widths and register codes for the track association
// block and its track memory.
// ----------------------------------------------------------------------------
package nta_pkg;

	localparam int COORD_BITS    = 12;
	localparam int AGE_BITS      = 8;
	localparam int GATE_BITS     = 13;
	localparam int IDX_OUT_BITS  = 4;
	localparam int CNT_OUT_BITS  = 5;
	localparam int DIST_BITS     = COORD_BITS + 2;
	localparam int SQ_BITS       = 2 * DIST_BITS;
	localparam int SUM_BITS      = SQ_BITS + 1;
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [AGE_BITS-1:0]     AGE_MAX         = 8'hFF;
	localparam logic [GATE_BITS-1:0]    GATE_RESET      = 13'd50;
	localparam logic [AGE_BITS-1:0]     MAX_AGE_RESET   = 8'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_GATE_RADIUS = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AGE     = 8'd1;
	localparam logic                    MODE_DETECT     = 1'b0;
	localparam logic                    MODE_FRAME_END  = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [COORD_BITS-1:0] det_x;
		logic [COORD_BITS-1:0] det_y;
		logic [COORD_BITS-1:0] det_w;
		logic [COORD_BITS-1:0] det_h;
	} item_t;

	typedef struct packed {
		logic [IDX_OUT_BITS-1:0] track_index;
		logic                    new_track;
		logic                    dropped;
		logic [CNT_OUT_BITS-1:0] live_count;
	} result_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} rect_t;

	typedef struct packed {
		rect_t               rect;
		logic [AGE_BITS-1:0] age;
	} entry_t;

	// Doubled centre, 2*lo + size.
	function automatic logic [DIST_BITS-1:0] dbl_centre(
		input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] size
	);
		dbl_centre = {1'b0, lo, 1'b0} + {2'b00, size};
	endfunction

	function automatic logic [DIST_BITS-1:0] abs_diff(
		input logic [DIST_BITS-1:0] a,
		input logic [DIST_BITS-1:0] b
	);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

[sv/nearest_track_association.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest track association
// Keeps an ordered table of tracked rectangles with ages, matches detections
// to the nearest track inside the gate and sweeps out old tracks at frame end.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and busy stays high
// until the result word appears on result with done high for one cycle; the
// receiver cannot stall it. For a detection, one squaring multiplier is shared
// by the gate and by both axes of every stored track, read one entry at a time
// from the track memory. A frame end does one memory read per track and one
// write per kept track while the table is compacted in place. Register writes
// are taken only while busy is low.
module nearest_track_association #(
	parameter int MAX_TRACKS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire nta_pkg::item_t                item,
	output logic                               done,
	output nta_pkg::result_t                   result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [nta_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [nta_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import nta_pkg::*;

	localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW = $clog2(MAX_TRACKS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TRACKS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_GATE   = 3'd1;
	localparam logic [2:0] ST_X      = 3'd2;
	localparam logic [2:0] ST_Y      = 3'd3;
	localparam logic [2:0] ST_LAST   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_SWEEP  = 3'd6;

	logic [2:0]           state_q;
	logic [GATE_BITS-1:0] gate_q;
	logic [AGE_BITS-1:0]  max_age_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        scan_q;
	logic [CW-1:0]        kept_q;
	logic                 pv_q;
	logic                 more_q;
	logic                 cmp_v_q;
	logic                 found_q;
	logic                 done_q;

	rect_t                det_q;
	logic [IW-1:0]        cur_q;
	logic [IW-1:0]        idx_s1;
	logic [IW-1:0]        cmp_idx_q;
	logic [IW-1:0]        best_idx_q;
	logic [DIST_BITS-1:0] dy_q;
	logic [SQ_BITS-1:0]   sq_q;
	logic [SQ_BITS-1:0]   acc_q;
	logic [SQ_BITS-1:0]   gate2_q;
	logic [SUM_BITS-1:0]  best_q;
	result_t              result_q;

	entry_t               rd_data;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	entry_t               wr_data;

	logic                 issue;
	logic [DIST_BITS-1:0] dx;
	logic [DIST_BITS-1:0] dy;
	logic [DIST_BITS-1:0] mul_a;
	logic [SQ_BITS-1:0]   prod;
	logic [SUM_BITS-1:0]  dsum;
	logic                 hit;
	logic                 keep;
	logic [AGE_BITS-1:0]  age_inc;
	logic                 sweep_end;
	logic                 room;
	logic [CW-1:0]        next_count;
	logic [IW-1:0]        dec_idx;
	logic [15:0]          idx_wide;
	logic [15:0]          cnt_wide;

	nta_track_mem #(
		.DEPTH (MAX_TRACKS),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;

	assign issue = (scan_q < count_q);
	assign dx    = abs_diff(dbl_centre(rd_data.rect.x, rd_data.rect.w),
		dbl_centre(det_q.x, det_q.w));
	assign dy    = abs_diff(dbl_centre(rd_data.rect.y, rd_data.rect.h),
		dbl_centre(det_q.y, det_q.h));

	always_comb begin
		unique case (state_q)
			ST_GATE: mul_a = {gate_q, 1'b0};
			ST_X:    mul_a = dx;
			default: mul_a = dy_q;
		endcase
	end

	assign prod = mul_a * mul_a;
	assign dsum = {1'b0, acc_q} + {1'b0, sq_q};
	assign hit  = (dsum < {1'b0, gate2_q}) && (!found_q || (dsum < best_q));

	assign keep      = pv_q && (rd_data.age <= max_age_q);
	assign age_inc   = (rd_data.age == AGE_MAX) ? rd_data.age : (rd_data.age + 1'b1);
	assign sweep_end = !issue && !pv_q;
	assign room      = (count_q < CNT_FULL);
	assign dec_idx   = found_q ? best_idx_q : count_q[IW-1:0];
	assign next_count = (!found_q && room) ? (count_q + 1'b1) : count_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[IW-1:0];
		if (state_q == ST_GATE) begin
			rd_en = (count_q != '0);
		end else if (state_q == ST_X || state_q == ST_SWEEP) begin
			rd_en = issue;
		end
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = dec_idx;
		wr_data.rect = det_q;
		wr_data.age  = '0;
		if (state_q == ST_DECIDE) begin
			wr_en = found_q || room;
		end else if (state_q == ST_SWEEP) begin
			wr_en        = keep;
			wr_addr      = kept_q[IW-1:0];
			wr_data.rect = rd_data.rect;
			wr_data.age  = age_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gate_q    <= GATE_RESET;
			max_age_q <= MAX_AGE_RESET;
			count_q   <= '0;
			scan_q    <= '0;
			kept_q    <= '0;
			pv_q      <= 1'b0;
			more_q    <= 1'b0;
			cmp_v_q   <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DECIDE) || (state_q == ST_SWEEP && sweep_end);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GATE_RADIUS) begin
					gate_q <= cfg_data[GATE_BITS-1:0];
				end else if (cfg_index == REG_MAX_AGE) begin
					max_age_q <= cfg_data[AGE_BITS-1:0];
				end
			end
			if (cmp_v_q) begin
				cmp_v_q <= 1'b0;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						scan_q  <= '0;
						kept_q  <= '0;
						pv_q    <= 1'b0;
						found_q <= 1'b0;
						state_q <= (item.mode == MODE_FRAME_END) ? ST_SWEEP : ST_GATE;
					end
				end
				ST_GATE: begin
					if (count_q != '0) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_X;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_X: begin
					more_q <= issue;
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					state_q <= ST_Y;
				end
				ST_Y: begin
					cmp_v_q <= 1'b1;
					state_q <= more_q ? ST_X : ST_LAST;
				end
				ST_LAST: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					count_q <= next_count;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					pv_q <= issue;
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (keep) begin
						kept_q <= kept_q + 1'b1;
					end
					if (sweep_end) begin
						count_q <= kept_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			det_q.x <= item.det_x;
			det_q.y <= item.det_y;
			det_q.w <= item.det_w;
			det_q.h <= item.det_h;
		end
		if (state_q == ST_GATE) begin
			gate2_q <= prod;
			cur_q   <= '0;
		end
		if (state_q == ST_X) begin
			sq_q   <= prod;
			dy_q   <= dy;
			idx_s1 <= cur_q;
			if (issue) begin
				cur_q <= scan_q[IW-1:0];
			end
		end
		if (state_q == ST_Y) begin
			acc_q     <= sq_q;
			sq_q      <= prod;
			cmp_idx_q <= idx_s1;
		end
		if (cmp_v_q && hit) begin
			best_q     <= dsum;
			best_idx_q <= cmp_idx_q;
		end
		if (state_q == ST_DECIDE) begin
			result_q.track_index <= (found_q || room) ? idx_wide[IDX_OUT_BITS-1:0] : '0;
			result_q.new_track   <= !found_q && room;
			result_q.dropped     <= !found_q && !room;
			result_q.live_count  <= cnt_wide[CNT_OUT_BITS-1:0];
		end else if (state_q == ST_SWEEP && sweep_end) begin
			result_q.track_index <= '0;
			result_q.new_track   <= 1'b0;
			result_q.dropped     <= 1'b0;
			result_q.live_count  <= cnt_wide[CNT_OUT_BITS-1:0];
		end
	end

	assign idx_wide = 16'(dec_idx);
	assign cnt_wide = (state_q == ST_SWEEP) ? 16'(kept_q) : 16'(next_count);

endmodule
`default_nettype wire

[sv/nta_track_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Track memory
// One write port and one registered read port holding the rectangle and age
// of each table position.
// ----------------------------------------------------------------------------
module nta_track_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire                  clk,
	input  wire                  wr_en,
	input  wire  [AW-1:0]        wr_addr,
	input  wire nta_pkg::entry_t wr_data,
	input  wire                  rd_en,
	input  wire  [AW-1:0]        rd_addr,
	output nta_pkg::entry_t      rd_data
);
	import nta_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire
